[rtl/core/stm_pkg.sv]
// Shared constants, types and state codes of the square tone mixer.
package stm_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned LEVEL_W     = 15;
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned SUM_W       = PHASE_W + 1;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned DIV_STEPS   = SUM_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // Twice the timer input clock, added to the phase counter on every mixed frame.
    localparam logic [SUM_W-1:0]   PHASE_STEP = 33'd2386364;
    localparam logic [LEVEL_W-1:0] TONE_HIGH  = 15'd24575;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEAKER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE    = 2'd2;

    typedef enum logic {
        PH_IDLE,
        PH_DIV
    } t_phase_state;

    typedef struct packed {
        logic start;   // a mixed frame was accepted: advance the phase
        logic clear;   // the half-period bound was written
    } t_phase_ctrl;

endpackage

[rtl/core/stm_mix.sv]
// Averages one sample with the tone level, rounding toward zero.
module stm_mix (
    input  logic signed [stm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic        [stm_pkg::LEVEL_W-1:0]  i_level,
    output logic signed [stm_pkg::SAMPLE_W-1:0] o_mixed
);

    logic signed [stm_pkg::SAMPLE_W:0] w_sum;
    logic signed [stm_pkg::SAMPLE_W:0] w_adj;

    always_comb begin
        w_sum = {i_sample[stm_pkg::SAMPLE_W-1], i_sample}
              + $signed({2'b00, i_level});
        // A negative odd sum needs one added so the shift truncates toward zero.
        w_adj = w_sum + $signed({{stm_pkg::SAMPLE_W{1'b0}}, w_sum[stm_pkg::SAMPLE_W]});
        o_mixed = w_adj[stm_pkg::SAMPLE_W:1];
    end

endmodule

[rtl/core/stm_phase.sv]
// Phase counter and tone level with a bit-serial remainder unit.
module stm_phase (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stm_pkg::t_phase_ctrl          i_ctrl,
    input  logic [stm_pkg::PHASE_W-1:0]   i_bound,
    output logic [stm_pkg::LEVEL_W-1:0]   o_level,
    output logic                          o_busy
);

    stm_pkg::t_phase_state r_state, n_state;
    logic [stm_pkg::PHASE_W-1:0]   r_phase, n_phase;
    logic [stm_pkg::LEVEL_W-1:0]   r_level, n_level;
    logic [stm_pkg::DIV_CNT_W-1:0] r_count, n_count;
    logic [stm_pkg::PHASE_W-1:0]   r_rem, n_rem;
    logic [stm_pkg::SUM_W-1:0]     r_dvd, n_dvd;

    logic [stm_pkg::PHASE_W-1:0] w_bound;
    logic [stm_pkg::SUM_W-1:0]   w_sum;
    logic [stm_pkg::SUM_W-1:0]   w_trial;
    logic [stm_pkg::SUM_W-1:0]   w_diff;
    logic                        w_fits;
    logic [stm_pkg::PHASE_W-1:0] w_rem_next;

    always_comb begin
        // A zero bound behaves as one.
        w_bound = (i_bound == '0) ? {{(stm_pkg::PHASE_W-1){1'b0}}, 1'b1} : i_bound;
        w_sum   = {1'b0, r_phase} + stm_pkg::PHASE_STEP;
        // One restoring step: bring in the next dividend bit, subtract if it fits.
        w_trial = {r_rem, r_dvd[stm_pkg::SUM_W-1]};
        w_diff  = w_trial - {1'b0, w_bound};
        w_fits  = (w_trial >= {1'b0, w_bound});
        w_rem_next = w_fits ? w_diff[stm_pkg::PHASE_W-1:0] : w_trial[stm_pkg::PHASE_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_level = r_level;
        n_count = r_count;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        case (r_state)
            stm_pkg::PH_IDLE: begin
                if (i_ctrl.clear) begin
                    n_phase = '0;
                    n_level = '0;
                end else if (i_ctrl.start) begin
                    if (w_sum >= {1'b0, w_bound}) begin
                        n_level = stm_pkg::TONE_HIGH - r_level;
                        n_dvd   = w_sum;
                        n_rem   = '0;
                        n_count = stm_pkg::DIV_CNT_W'(stm_pkg::DIV_STEPS);
                        n_state = stm_pkg::PH_DIV;
                    end else begin
                        n_phase = w_sum[stm_pkg::PHASE_W-1:0];
                    end
                end
            end
            stm_pkg::PH_DIV: begin
                n_rem   = w_rem_next;
                n_dvd   = {r_dvd[stm_pkg::SUM_W-2:0], 1'b0};
                n_count = r_count - 1'b1;
                if (r_count == stm_pkg::DIV_CNT_W'(1)) begin
                    n_phase = w_rem_next;
                    n_state = stm_pkg::PH_IDLE;
                end
            end
            default: begin
                n_state = stm_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stm_pkg::PH_IDLE;
            r_phase <= '0;
            r_level <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    assign o_level = r_level;
    assign o_busy  = (r_state != stm_pkg::PH_IDLE);

endmodule

[rtl/core/square_tone_mixer_unit.sv]
// Top level of the square tone mixer: configuration, mixing and output register.
//
// The block mixes a square tone, like that of a PC speaker, into a stream of
// audio frames. Each frame beat carries a left and a right sample and an
// end-of-block mark; the result beat carries the mixed samples and the mark.
// With the speaker enabled each channel in use becomes the average of the
// sample and the tone level, rounded toward zero; in mono mode only the left
// channel is mixed. The tone flips between 0 and 24575 whenever the phase
// counter, advanced by 2386364 on every mixed frame, reaches the half-period
// bound, and it then keeps the remainder modulo the bound. The result of a
// frame is registered at the output in the cycle after it is accepted. Frames
// that pass through, or whose phase sum stays below the bound, leave the
// remainder unit idle and can arrive back to back while the output is not
// stalled. A frame that wraps the phase starts a bit-serial remainder unit that
// takes one dividend bit per cycle over every bit of the phase sum; the next
// frame is accepted only once it is done. A result waiting at the output does
// not stop that work; a full, stalled output register holds the input too.
// The user must write configuration through a plain write port only while
// the block is idle, which it does not enforce. Writing the half-period bound
// clears the phase counter and tone level; writes to an unused index are ignored.
module square_tone_mixer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic        [stm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [stm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Frame input
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [stm_pkg::SAMPLE_W-1:0]   i_sample_left,
    input  logic signed [stm_pkg::SAMPLE_W-1:0]   i_sample_right,
    input  logic                                  i_last_frame,
    // Result output
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [stm_pkg::SAMPLE_W-1:0]   o_mixed_left,
    output logic signed [stm_pkg::SAMPLE_W-1:0]   o_mixed_right,
    output logic                                  o_end_of_block
);

    // Configuration registers.
    logic                          r_speaker_enable;
    logic [stm_pkg::PHASE_W-1:0]   r_half_period_bound;
    logic                          r_stereo_mode;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    logic signed [stm_pkg::SAMPLE_W-1:0] r_mixed_left, n_mixed_left;
    logic signed [stm_pkg::SAMPLE_W-1:0] r_mixed_right, n_mixed_right;
    logic                          r_end_of_block, n_end_of_block;

    logic                          w_accept;
    logic                          w_busy;
    logic [stm_pkg::LEVEL_W-1:0]   w_level;
    logic signed [stm_pkg::SAMPLE_W-1:0] w_mix_left;
    logic signed [stm_pkg::SAMPLE_W-1:0] w_mix_right;
    stm_pkg::t_phase_ctrl          w_phase_ctrl;

    // The tone level only changes once the frame that used it has been taken,
    // so both channels are mixed on the cycle the frame is accepted.
    stm_mix u_mix_left (
        .i_sample (i_sample_left),
        .i_level  (w_level),
        .o_mixed  (w_mix_left)
    );

    stm_mix u_mix_right (
        .i_sample (i_sample_right),
        .i_level  (w_level),
        .o_mixed  (w_mix_right)
    );

    stm_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_phase_ctrl),
        .i_bound  (r_half_period_bound),
        .o_level  (w_level),
        .o_busy   (w_busy)
    );

    // The input is held while the remainder unit runs or a stalled result
    // still occupies the output register.
    assign o_stall  = w_busy || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_phase_ctrl.start = w_accept && r_speaker_enable;
        w_phase_ctrl.clear = i_cfg_wr_en && (i_cfg_index == stm_pkg::CFG_HALF_PERIOD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speaker_enable    <= 1'b0;
            r_half_period_bound <= {{(stm_pkg::PHASE_W-1){1'b0}}, 1'b1};
            r_stereo_mode       <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                stm_pkg::CFG_SPEAKER_ENABLE: begin
                    r_speaker_enable <= i_cfg_wdata[0];
                end
                stm_pkg::CFG_HALF_PERIOD: begin
                    r_half_period_bound <= i_cfg_wdata[stm_pkg::PHASE_W-1:0];
                end
                stm_pkg::CFG_STEREO_MODE: begin
                    r_stereo_mode <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid    = r_out_valid;
        n_mixed_left   = r_mixed_left;
        n_mixed_right  = r_mixed_right;
        n_end_of_block = r_end_of_block;
        if (w_accept) begin
            n_out_valid    = 1'b1;
            n_mixed_left   = r_speaker_enable ? w_mix_left : i_sample_left;
            n_mixed_right  = (r_speaker_enable && r_stereo_mode) ? w_mix_right
                                                                 : i_sample_right;
            n_end_of_block = i_last_frame;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mixed_left   <= n_mixed_left;
        r_mixed_right  <= n_mixed_right;
        r_end_of_block <= n_end_of_block;
    end

    assign o_valid        = r_out_valid;
    assign o_mixed_left   = r_mixed_left;
    assign o_mixed_right  = r_mixed_right;
    assign o_end_of_block = r_end_of_block;

endmodule

[rtl/core/stm_checker.sv]
// Port-level checks of the square tone mixer, bound to the top level.
module stm_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic                                  i_last_frame,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [stm_pkg::SAMPLE_W-1:0]   o_mixed_left,
    input logic signed [stm_pkg::SAMPLE_W-1:0]   o_mixed_right,
    input logic                                  o_end_of_block
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mixed_left)
            && $stable(o_mixed_right) && $stable(o_end_of_block)))
        else $error("stalled result beat changed");

    // Every accepted frame shows a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted frame produced no result");

    // The end-of-block mark travels with its frame.
    a_mark_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_end_of_block == $past(i_last_frame)))
        else $error("end-of-block mark lost");

    // A full, stalled output register must hold the input back.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("frame accepted over a waiting result");

endmodule

bind square_tone_mixer_unit stm_checker u_stm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last_frame   (i_last_frame),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_mixed_left   (o_mixed_left),
    .o_mixed_right  (o_mixed_right),
    .o_end_of_block (o_end_of_block)
);

[tb/square_tone_mixer_unit_test.sv]
// Self-checking testbench of the square tone mixer unit: directed cases, then random frames.
module square_tone_mixer_unit_test;
    import stm_pkg::*;

    localparam int HALF_CYCLE       = 10;
    // A wrapping frame keeps the remainder unit busy even after its result beat has
    // left, so configuration writes wait until it has finished.
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_CYCLES      = 150;
    localparam int PHASES_PER_ROUND = 3;
    localparam int FRAMES_PER_PHASE = 105;
    localparam int DRAIN_LIMIT      = 100000;
    localparam int MAX_PRINTED      = 40;
    localparam int unsigned RUN_LIMIT = 3_000_000 * 2 * HALF_CYCLE;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       eob;
    } t_mix_beat;

    // Block ports, all driven from time zero.
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;
    logic                         fr_valid  = 1'b0;
    logic                         fr_stall;
    logic signed [SAMPLE_W-1:0]   fr_left   = '0;
    logic signed [SAMPLE_W-1:0]   fr_right  = '0;
    logic                         fr_last   = 1'b0;
    logic                         mx_valid;
    logic                         rx_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0]   mx_left;
    logic signed [SAMPLE_W-1:0]   mx_right;
    logic                         mx_eob;

    // Our own copy of the configuration and of the tone state.
    logic                 tone_on       = 1'b0;
    logic [PHASE_W-1:0]   half_bound    = 32'd1;
    logic                 both_channels = 1'b1;
    logic [PHASE_W-1:0]   phase_acc     = '0;
    logic [LEVEL_W-1:0]   tone_lvl      = '0;

    t_mix_beat pending_mix[$];

    int error_count   = 0;
    int frame_count   = 0;
    int flip_count    = 0;
    int write_count   = 0;
    int results_seen  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off: toggling hold_go asks for one.
    logic hold_go   = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    square_tone_mixer_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_we),
        .i_cfg_index    (cfg_idx),
        .i_cfg_wdata    (cfg_data),
        .i_valid        (fr_valid),
        .o_stall        (fr_stall),
        .i_sample_left  (fr_left),
        .i_sample_right (fr_right),
        .i_last_frame   (fr_last),
        .o_valid        (mx_valid),
        .i_stall        (rx_stall),
        .o_mixed_left   (mx_left),
        .o_mixed_right  (mx_right),
        .o_end_of_block (mx_eob)
    );

    always #(HALF_CYCLE) clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at result %0d: %s, got %0h, want %0h",
                     results_seen, what, got, want);
    endtask

    // Average of a sample and the current tone level, truncated toward zero.
    function automatic logic signed [SAMPLE_W-1:0] tone_average(
            input logic signed [SAMPLE_W-1:0] s);
        int acc;
        acc = int'(s) + int'(tone_lvl);
        acc = acc / 2;
        return acc[SAMPLE_W-1:0];
    endfunction

    // Works out the result of one accepted frame and advances the tone state.
    task automatic predict_mixed_frame(input logic signed [SAMPLE_W-1:0] l,
                                       input logic signed [SAMPLE_W-1:0] r,
                                       input logic last);
        t_mix_beat        beat;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] divisor;
        beat.left  = l;
        beat.right = r;
        beat.eob   = last;
        if (tone_on) begin
            // A zero bound behaves as a bound of one.
            divisor = {1'b0, half_bound};
            if (half_bound == '0)
                divisor = SUM_W'(1);
            beat.left = tone_average(l);
            if (both_channels)
                beat.right = tone_average(r);
            sum = {1'b0, phase_acc} + PHASE_STEP;
            if (sum >= divisor) begin
                phase_acc = PHASE_W'(sum % divisor);
                tone_lvl  = TONE_HIGH - tone_lvl;
                flip_count++;
            end else begin
                phase_acc = sum[PHASE_W-1:0];
            end
        end
        pending_mix.push_back(beat);
        frame_count++;
    endtask

    // Writes one register; the model follows at the write edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_SPEAKER_ENABLE: tone_on = data[0];
            CFG_HALF_PERIOD: begin
                half_bound = data;
                phase_acc  = '0;
                tone_lvl   = '0;
            end
            CFG_STEREO_MODE: both_channels = data[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
        write_count++;
    endtask

    // Offers one frame beat, sometimes after a random gap, and returns at the edge that takes it.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r,
                              input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            fr_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        fr_valid <= 1'b1;
        fr_left  <= l;
        fr_right <= r;
        fr_last  <= last;
        do
            @(posedge clk);
        while (fr_stall);
        predict_mixed_frame(l, r, last);
    endtask

    // Lets every outstanding result out and the remainder unit finish.
    task automatic settle_block();
        fr_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] pick_bound();
        logic [SUM_W-1:0] scaled;
        scaled = PHASE_STEP * $urandom_range(40, 1);
        case ($urandom_range(4))
            0: return PHASE_W'($urandom_range(3));
            1: return scaled[PHASE_W-1:0] + PHASE_W'($urandom_range(50)) - 25;
            2: return $urandom;
            3: return '1;
            default: return PHASE_W'($urandom_range(60_000_000, 1));
        endcase
    endfunction

    // Receiver side: random stalls, or a long hold-off when one is asked for.
    always @(posedge clk) begin : drive_rx_stall
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_stall  <= 1'b1;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            rx_stall  <= 1'b1;
        end else begin
            rx_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Every result beat is checked against the oldest expectation.
    always @(posedge clk) begin : check_results
        t_mix_beat want;
        if (rst_n && mx_valid && !rx_stall) begin
            if (pending_mix.size() == 0) begin
                flag_mismatch("result beat with nothing expected", 0, 0);
            end else begin
                want = pending_mix.pop_front();
                if (mx_left !== want.left)
                    flag_mismatch("mixed_left", 32'(mx_left), 32'(want.left));
                if (mx_right !== want.right)
                    flag_mismatch("mixed_right", 32'(mx_right), 32'(want.right));
                if (mx_eob !== want.eob)
                    flag_mismatch("end_of_block", 32'(mx_eob), 32'(want.eob));
            end
            results_seen++;
        end
    end

    // After reset the speaker is off, so frames come back unchanged.
    task automatic test_reset_passthrough();
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b1);
        send_frame(16'sh0000, 16'shFFFF, 1'b0);
        send_frame(pick_sample(), pick_sample(), 1'b1);
    endtask

    // A zero bound flips the tone on every mixed frame. The enable write carries
    // junk in its upper bits, which must be dropped.
    task automatic test_zero_bound();
        settle_block();
        write_reg(CFG_SPEAKER_ENABLE, 32'hFFFF_FFF1);
        write_reg(CFG_HALF_PERIOD, 32'd0);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'shFFFF, 16'sh0001, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
    endtask

    // A sum that lands exactly on the bound wraps; one short of it does not.
    task automatic test_exact_bound();
        settle_block();
        write_reg(CFG_HALF_PERIOD, PHASE_W'(PHASE_STEP));
        send_frame(16'sh1234, 16'shEDCB, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        settle_block();
        write_reg(CFG_HALF_PERIOD, PHASE_W'(PHASE_STEP) + 1);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_frame(16'sh8000, 16'sh8001, 1'b0);
    endtask

    // Mono mixes only the left channel; writes to the unused index and a repeated
    // enable write leave the tone state alone.
    task automatic test_mono_and_unused();
        settle_block();
        write_reg(CFG_STEREO_MODE, 32'hFFFF_FFFE);
        write_reg(CFG_HALF_PERIOD, 32'd0);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'sh4000, 16'shC000, 1'b0);
        settle_block();
        write_reg(CFG_UNUSED, $urandom);
        write_reg(CFG_SPEAKER_ENABLE, 32'h0000_0001);
        send_frame(16'sh7FFF, 16'sh0000, 1'b0);
        send_frame(16'sh8000, 16'shFFFF, 1'b1);
    endtask

    // The largest bound: the phase climbs without wrapping.
    task automatic test_max_bound();
        settle_block();
        write_reg(CFG_STEREO_MODE, 32'h0000_0001);
        write_reg(CFG_HALF_PERIOD, 32'hFFFF_FFFF);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    endtask

    // The receiver holds off for a long stretch while frames keep coming, so the
    // output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        int n;
        settle_block();
        write_reg(CFG_SPEAKER_ENABLE, 32'h0000_0000);
        hold_go <= ~hold_go;
        for (n = 0; n < 6; n++)
            send_frame(pick_sample(), pick_sample(), n[0]);
    endtask

    // Random frames under random configurations, over the three idle settings.
    task automatic test_random_traffic();
        int round;
        int ph;
        int n;
        logic [CFG_DATA_W-1:0] word;
        for (round = 0; round < 3; round++) begin
            case (round)
                0: begin send_idle_pct = 15; recv_idle_pct = 53; end
                1: begin send_idle_pct = 53; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (ph = 0; ph < PHASES_PER_ROUND; ph++) begin
                settle_block();
                word    = $urandom;
                word[0] = ($urandom_range(4) != 0);
                write_reg(CFG_SPEAKER_ENABLE, word);
                word    = $urandom;
                word[0] = $urandom_range(1);
                write_reg(CFG_STEREO_MODE, word);
                if ($urandom_range(2) == 0)
                    write_reg(CFG_UNUSED, $urandom);
                write_reg(CFG_HALF_PERIOD, pick_bound());
                for (n = 0; n < FRAMES_PER_PHASE; n++)
                    send_frame(pick_sample(), pick_sample(), ($urandom_range(7) == 0));
            end
        end
    endtask

    initial begin : run_tests
        int wait_cycles;
        send_idle_pct = 15;
        recv_idle_pct = 53;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_passthrough();
        test_zero_bound();
        test_exact_bound();
        test_mono_and_unused();
        test_max_bound();
        test_output_backpressure();
        test_random_traffic();

        fr_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_mix.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            wait_cycles++;
        end
        if (pending_mix.size() != 0)
            flag_mismatch("results still outstanding at the end", pending_mix.size(), 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d frames (%0d tone flips) under %0d register writes,",
                 frame_count, flip_count, write_count);
        $display("with zero, exact, random and full-scale bounds, mono and stereo, and back-pressure");
        if (error_count == 0)
            $display("square_tone_mixer_unit_test: done, clean");
        else
            $display("square_tone_mixer_unit_test: done, errors");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("square_tone_mixer_unit_test: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/core/stm_pkg.sv
rtl/core/stm_mix.sv
rtl/core/stm_phase.sv
rtl/core/square_tone_mixer_unit.sv
rtl/core/stm_checker.sv
tb/square_tone_mixer_unit_test.sv
